@@ rtl/vrt_pkg.sv @@
// vrt_pkg: shared types and constants for the camera reply tracker
// no dependencies
package vrt_pkg;

  typedef enum logic [1:0] {
    REQ_BYTE = 2'd0,
    REQ_CMD  = 2'd1,
    REQ_TICK = 2'd2,
    REQ_NONE = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    KIND_DATA   = 3'd0,
    KIND_ACK    = 3'd1,
    KIND_DONE   = 3'd2,
    KIND_ERROR  = 3'd3,
    KIND_REJECT = 3'd4
  } kind_e;

  localparam logic [7:0] BYTE_TERM   = 8'hFF;
  localparam logic [7:0] HDR_LO      = 8'h90;
  localparam logic [7:0] HDR_HI      = 8'h9F;
  localparam logic [7:0] DATA_A      = 8'h4F;
  localparam logic [7:0] DATA_B      = 8'h5F;
  localparam logic [3:0] CLS_ACK     = 4'h4;
  localparam logic [3:0] CLS_DONE    = 4'h5;
  localparam logic [3:0] CLS_ERROR   = 4'h6;
  localparam logic [7:0] ERR_TIMEOUT = 8'hFE;

  localparam int unsigned EntryW = 39;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  rx_byte;
    logic [7:0]  cmd_tag;
    logic [14:0] cmd_timeout;
  } in_word_t;

  typedef struct packed {
    logic [2:0] out_kind;
    logic [7:0] out_tag;
    logic [3:0] out_socket;
    logic [7:0] error_code;
    logic [7:0] data_byte;
    logic       last;
  } out_word_t;

  // command entry: tag, timeout, issue tick
  typedef struct packed {
    logic [15:0] stamp;
    logic [14:0] tmo;
    logic [7:0]  tag;
  } entry_t;

endpackage

@@ rtl/vrt_ram.sv @@
// vrt_ram: generic single-port-write ram with registered read
// no dependencies
module vrt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AW   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

@@ rtl/visca_reply_tracker.sv @@
// visca_reply_tracker: top level, sequencer over the pending queue and socket table
// depends on vrt_pkg and vrt_ram
//
// usage: one input channel (in_valid_i/in_ready_o/in_word_i) takes a reply byte,
// a command-issued event or a tick. one output channel (out_valid_o/out_ready_i/
// out_word_o) gives result words; the last word of an item has last set.
// each item is handled alone by a small sequencer. a queued command or a reply
// byte with no result leaves it idle, a single result word passes through the
// emit state, the two header words of a data frame pass through emit, data and
// emit again; an ack reads the pending queue memory once, then emits.
// a completion, error or tick walks the socket table memory in order: an empty
// socket is skipped from the scan state, a live one goes on to the eval state
// (read, then decide); the walk is what sets the rate for ticks and retires.
// each result word sits in an output register; while the receiver stalls the
// sequencer waits on that register and nothing is lost.
// reset clears queue pointers, valid bits, tick counter and framing state; the
// memories hold no reset value and are never read before being written, so no
// clearing pass is needed.
// in_ready_o is high only while the sequencer is idle.
module visca_reply_tracker
  import vrt_pkg::*;
#(
  parameter int unsigned PENDING_DEPTH = 8,
  parameter int unsigned SOCKET_COUNT  = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);
  localparam int unsigned PW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int unsigned SW = (SOCKET_COUNT > 1) ? $clog2(SOCKET_COUNT) : 1;
  localparam int unsigned CW = $clog2(PENDING_DEPTH + 1);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_ACKR = 6'b000010, // pending read issued
    ST_SCAN = 6'b000100, // socket read issued
    ST_EVAL = 6'b001000, // socket data available
    ST_EMIT = 6'b010000, // waiting for output register
    ST_DATA = 6'b100000  // second data word of a frame
  } state_e;

  state_e      state_q, state_d;
  logic [PW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [SOCKET_COUNT-1:0] valid_q, valid_d;
  logic [15:0] tick_q, tick_d;
  logic [1:0]  fpos_q, fpos_d;
  logic [7:0]  first_q, first_d, second_q, second_d, third_q, third_d;
  logic [SW:0] sock_q, sock_d;     // scan index, one wider for end detect
  logic        tick_mode_q, tick_mode_d; // 1 tick scan, 0 retire scan
  logic        found_q, found_d;   // some result already held in this scan
  out_word_t   pend_q, pend_d;     // word waiting to be shown
  state_e      ret_q, ret_d;       // state after emit
  logic        ovalid_q, ovalid_d;
  out_word_t   oword_q, oword_d;

  // pending queue memory
  logic          pq_we;
  logic [PW-1:0] pq_waddr, pq_raddr;
  entry_t        pq_wdata, pq_rdata;
  vrt_ram #(.Width(EntryW), .Depth(PENDING_DEPTH)) u_pq (
    .clk_i, .we_i(pq_we), .waddr_i(pq_waddr), .wdata_i(pq_wdata),
    .raddr_i(pq_raddr), .rdata_o(pq_rdata)
  );

  // socket table memory
  logic          st_we;
  logic [SW-1:0] st_waddr, st_raddr;
  entry_t        st_wdata, st_rdata;
  vrt_ram #(.Width(EntryW), .Depth(SOCKET_COUNT)) u_st (
    .clk_i, .we_i(st_we), .waddr_i(st_waddr), .wdata_i(st_wdata),
    .raddr_i(st_raddr), .rdata_o(st_rdata)
  );

  logic hdr, is_data2, is_data_b;
  logic [15:0] age;
  logic [PW-1:0] tail;
  logic [CW+PW-1:0] tail_sum;
  logic accept, oslot_free;
  out_word_t w;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = ovalid_q;
  assign out_word_o  = oword_q;
  assign oslot_free  = !ovalid_q || out_ready_i;
  assign hdr         = (first_q >= HDR_LO) && (first_q <= HDR_HI);
  assign is_data2    = (second_q == DATA_A) || (second_q == DATA_B);
  assign is_data_b   = (in_word_i.rx_byte == DATA_A) || (in_word_i.rx_byte == DATA_B);
  assign age         = tick_q - st_rdata.stamp;
  assign tail_sum    = (CW+PW)'(head_q) + (CW+PW)'(count_q);
  // head below depth and count at most depth, so one subtract wraps the tail
  assign tail        = (tail_sum >= (CW+PW)'(PENDING_DEPTH)) ?
                       PW'(tail_sum - (CW+PW)'(PENDING_DEPTH)) : PW'(tail_sum);

  always_comb begin
    state_d = state_q; head_d = head_q; count_d = count_q;
    valid_d = valid_q; tick_d = tick_q; fpos_d = fpos_q;
    first_d = first_q; second_d = second_q; third_d = third_q;
    sock_d = sock_q; tick_mode_d = tick_mode_q; found_d = found_q;
    pend_d = pend_q; ret_d = ret_q;
    ovalid_d = ovalid_q && !out_ready_i; oword_d = oword_q;
    pq_we = 1'b0; pq_waddr = tail; pq_raddr = head_q;
    pq_wdata = '{stamp: tick_q, tmo: in_word_i.cmd_timeout, tag: in_word_i.cmd_tag};
    st_we = 1'b0; st_waddr = second_q[SW-1:0]; st_raddr = sock_q[SW-1:0];
    st_wdata = pq_rdata;
    w = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_word_i.req_type)
            REQ_CMD: begin
              if (32'(count_q) >= PENDING_DEPTH) begin
                w.out_kind = KIND_REJECT; w.out_tag = in_word_i.cmd_tag; w.last = 1'b1;
                pend_d = w; ret_d = ST_IDLE; state_d = ST_EMIT;
              end else begin
                pq_we = 1'b1; count_d = count_q + 1'b1;
              end
            end
            REQ_TICK: begin
              tick_d = tick_q + 16'd1; tick_mode_d = 1'b1; found_d = 1'b0;
              sock_d = '0; state_d = ST_SCAN;
            end
            REQ_BYTE: begin
              if (in_word_i.rx_byte != BYTE_TERM) begin
                case (fpos_q)
                  2'd0: begin first_d = in_word_i.rx_byte; fpos_d = 2'd1; end
                  2'd1: begin
                    second_d = in_word_i.rx_byte; fpos_d = 2'd2;
                    if (hdr && is_data_b) begin
                      w.out_kind = KIND_DATA; w.out_socket = in_word_i.rx_byte[3:0];
                      w.data_byte = first_q;
                      pend_d = w; ret_d = ST_DATA; state_d = ST_EMIT;
                    end
                  end
                  default: begin
                    if (fpos_q == 2'd2) begin
                      third_d = in_word_i.rx_byte; fpos_d = 2'd3;
                    end
                    if (hdr && is_data2) begin
                      w.out_kind = KIND_DATA; w.out_socket = second_q[3:0];
                      w.data_byte = in_word_i.rx_byte; w.last = 1'b1;
                      pend_d = w; ret_d = ST_IDLE; state_d = ST_EMIT;
                    end
                  end
                endcase
              end else begin
                fpos_d = 2'd0;
                if (fpos_q >= 2'd2 && hdr) begin
                  if (is_data2) begin
                    w.out_kind = KIND_DATA; w.out_socket = second_q[3:0];
                    w.data_byte = BYTE_TERM; w.last = 1'b1;
                    pend_d = w; ret_d = ST_IDLE; state_d = ST_EMIT;
                  end else if (second_q[7:4] == CLS_ACK) begin
                    if (count_q != '0 && 32'(second_q[3:0]) < SOCKET_COUNT)
                      state_d = ST_ACKR;
                  end else if (second_q[7:4] == CLS_DONE || second_q[7:4] == CLS_ERROR) begin
                    // error byte only counts if the frame reached it
                    if (fpos_q != 2'd3) third_d = '0;
                    tick_mode_d = 1'b0; found_d = 1'b0; sock_d = '0; state_d = ST_SCAN;
                  end
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_ACKR: begin
        st_we = 1'b1;
        valid_d[second_q[SW-1:0]] = 1'b1;
        head_d = (32'(head_q) == PENDING_DEPTH - 1) ? '0 : head_q + 1'b1;
        count_d = count_q - 1'b1;
        w.out_kind = KIND_ACK; w.out_tag = pq_rdata.tag;
        w.out_socket = second_q[3:0]; w.last = 1'b1;
        pend_d = w; ret_d = ST_IDLE; state_d = ST_EMIT;
      end
      ST_SCAN: begin
        // skip empty sockets without waiting for the memory read
        if (32'(sock_q) >= SOCKET_COUNT) begin
          state_d = ST_IDLE;
          if (found_q) begin
            // mark the previously held word as last
            pend_d.last = 1'b1;
          end
        end else if (!valid_q[sock_q[SW-1:0]]) begin
          sock_d = sock_q + 1'b1;
        end else begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (tick_mode_q) begin
          if (age > 16'(st_rdata.tmo)) begin
            valid_d[sock_q[SW-1:0]] = 1'b0;
            w.out_kind = KIND_ERROR; w.out_tag = st_rdata.tag;
            w.out_socket = 4'(sock_q); w.error_code = ERR_TIMEOUT;
            // held until next expiry or end of scan decides last
            if (found_q) begin
              ret_d = ST_SCAN;
            end
            found_d = 1'b1;
          end
          sock_d = sock_q + 1'b1;
          state_d = ST_SCAN;
          if (age > 16'(st_rdata.tmo)) begin
            if (found_q) begin
              // send the older held word, keep the new one
              oword_d = pend_q; ovalid_d = 1'b1;
              state_d = oslot_free ? ST_SCAN : ST_EVAL;
              if (!oslot_free) begin
                sock_d = sock_q; found_d = found_q; valid_d = valid_q;
                ovalid_d = ovalid_q && !out_ready_i; oword_d = oword_q;
              end else pend_d = w;
            end else pend_d = w;
          end
        end else begin
          valid_d[sock_q[SW-1:0]] = 1'b0;
          w.out_kind = (second_q[7:4] == CLS_DONE) ? KIND_DONE : KIND_ERROR;
          w.out_tag = st_rdata.tag; w.out_socket = 4'(sock_q);
          if (second_q[7:4] == CLS_ERROR) w.error_code = third_q;
          w.last = 1'b1;
          pend_d = w; ret_d = ST_IDLE; state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (oslot_free) begin
          oword_d = pend_q; ovalid_d = 1'b1; state_d = ret_q;
        end
      end
      ST_DATA: begin
        w.out_kind = KIND_DATA; w.out_socket = second_q[3:0];
        w.data_byte = second_q; w.last = 1'b1;
        pend_d = w; ret_d = ST_IDLE; state_d = ST_EMIT;
      end
      default: state_d = ST_IDLE;
    endcase

    // end of a tick or retire scan with a held word: flush it
    if (state_q == ST_SCAN && 32'(sock_q) >= SOCKET_COUNT && found_q) begin
      pend_d = pend_q; pend_d.last = 1'b1; ret_d = ST_IDLE; state_d = ST_EMIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; head_q <= '0; count_q <= '0; valid_q <= '0;
      tick_q <= '0; fpos_q <= '0; first_q <= '0; second_q <= '0; third_q <= '0;
      sock_q <= '0; tick_mode_q <= 1'b0; found_q <= 1'b0; ovalid_q <= 1'b0;
      ret_q <= ST_IDLE;
    end else begin
      state_q <= state_d; head_q <= head_d; count_q <= count_d; valid_q <= valid_d;
      tick_q <= tick_d; fpos_q <= fpos_d; first_q <= first_d; second_q <= second_d;
      third_q <= third_d; sock_q <= sock_d; tick_mode_q <= tick_mode_d;
      found_q <= found_d; ovalid_q <= ovalid_d; ret_q <= ret_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d; oword_q <= oword_d;
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= PENDING_DEPTH) else $error("pending count overflow");
  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ACKR) |=> !in_ready_o) else $error("ack must emit before idle");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(out_word_o)) else $error("output word changed");
  a_ack_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ACKR) |-> count_q != '0) else $error("ack on empty queue");
`endif
endmodule
